>>> rtl/core/sfl_pkg.sv
// Shared constants, types and record formats of the stream frame loss monitor.
package sfl_pkg;

    localparam int STREAMS     = 256;
    localparam int IDX_BITS    = $clog2(STREAMS);
    localparam int SID_BITS    = 8;
    localparam int SEQ_BITS    = 16;
    localparam int TIME_BITS   = 48;
    localparam int MAC_BITS    = 48;
    localparam int DELAY_BITS  = 48;
    localparam int PRIO_BITS   = 3;
    localparam int CNT_BITS    = 32;
    localparam int DELTA_BITS  = 17;
    localparam int CLASS_BITS  = 2;
    localparam int ENTRY_BITS  = SEQ_BITS + CNT_BITS;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_IN_ORDER = 2'd0,
        CLS_GAP      = 2'd1,
        CLS_LATE     = 2'd2
    } frame_class_t;

    typedef struct packed {
        logic                  addr_mismatch;
        logic [DELAY_BITS-1:0] path_delay;
        logic                  delay_error;
        logic [SID_BITS-1:0]   stream_id;
        logic [SEQ_BITS-1:0]   seq_no;
        logic [PRIO_BITS-1:0]  priority_req;
    } front_rec_t;

endpackage

>>> rtl/core/sfl_frame_if.sv
// Item channel that carries received frame descriptors.
interface sfl_frame_if
    import sfl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MAC_BITS-1:0]  dest_mac;
    logic [SID_BITS-1:0]  stream_id;
    logic [SEQ_BITS-1:0]  seq_no;
    logic [PRIO_BITS-1:0] priority_req;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] injection_time;

    modport source (
        output valid, dest_mac, stream_id, seq_no, priority_req,
               arrival_time, injection_time,
        input  ready
    );

    modport sink (
        input  valid, dest_mac, stream_id, seq_no, priority_req,
               arrival_time, injection_time,
        output ready
    );
endinterface

>>> rtl/core/sfl_result_if.sv
// Item channel that carries per-frame check results.
interface sfl_result_if
    import sfl_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         addr_mismatch;
    logic [DELAY_BITS-1:0]        path_delay;
    logic                         delay_error;
    logic [CLASS_BITS-1:0]        frame_class;
    logic signed [CNT_BITS-1:0]   lost_total;
    logic signed [DELTA_BITS-1:0] lost_delta;
    logic [SID_BITS-1:0]          out_stream;
    logic [PRIO_BITS-1:0]         out_priority;

    modport source (
        output valid, addr_mismatch, path_delay, delay_error, frame_class,
               lost_total, lost_delta, out_stream, out_priority,
        input  ready
    );

    modport sink (
        input  valid, addr_mismatch, path_delay, delay_error, frame_class,
               lost_total, lost_delta, out_stream, out_priority,
        output ready
    );
endinterface

>>> rtl/core/sfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/sfl_front.sv
// Front part: own-address register, destination check and delay computation.
module sfl_front
    import sfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [MAC_BITS-1:0] cfg_wr_data,
    sfl_frame_if.sink           frame,
    output logic                push_valid,
    input  logic                push_ready,
    output front_rec_t          push_rec
);
    logic [MAC_BITS-1:0] own_mac_reg;
    logic                later;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            own_mac_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        later                  = frame.arrival_time > frame.injection_time;
        push_rec.addr_mismatch = frame.dest_mac != own_mac_reg;
        push_rec.path_delay    = later
            ? DELAY_BITS'(frame.arrival_time - frame.injection_time) : '0;
        push_rec.delay_error   = !later;
        push_rec.stream_id     = frame.stream_id;
        push_rec.seq_no        = frame.seq_no;
        push_rec.priority_req  = frame.priority_req;
    end

    assign push_valid  = frame.valid;
    assign frame.ready = push_ready;
endmodule

>>> rtl/core/sfl_queue.sv
// Short queue of front-part frame records between the front and back parts.
module sfl_queue
    import sfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  front_rec_t push_rec,
    output logic       pop_valid,
    input  logic       pop_ready,
    output front_rec_t pop_rec
);
    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    front_rec_t          entries [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                push;
    logic                pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_rec    = entries[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

>>> rtl/core/sfl_back.sv
// Back part: per-stream sequence tracking, loss accounting and result register.
module sfl_back
    import sfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  front_rec_t pop_rec,
    sfl_result_if.source result
);
    typedef enum logic {
        ST_FETCH,
        ST_EXEC
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    front_rec_t             work_reg;
    logic [STREAMS-1:0]     seen_reg;
    logic                   out_valid_reg;
    logic                   out_mismatch_reg;
    logic [DELAY_BITS-1:0]  out_delay_reg;
    logic                   out_derr_reg;
    frame_class_t           out_class_reg;
    logic [CNT_BITS-1:0]    out_total_reg;
    logic [DELTA_BITS-1:0]  out_delta_reg;
    logic [SID_BITS-1:0]    out_stream_reg;
    logic [PRIO_BITS-1:0]   out_prio_reg;

    logic [IDX_BITS-1:0]    work_idx;
    logic [IDX_BITS-1:0]    ram_raddr;
    logic [ENTRY_BITS-1:0]  ram_rdata;
    logic [ENTRY_BITS-1:0]  ram_wdata;
    logic                   seen;
    logic [SEQ_BITS-1:0]    last_seq;
    logic [CNT_BITS-1:0]    lost_old;
    logic [SEQ_BITS:0]      expected;
    logic [SEQ_BITS:0]      seq_ext;
    frame_class_t           cls;
    logic [DELTA_BITS-1:0]  delta;
    logic [CNT_BITS-1:0]    lost_new;
    logic [SEQ_BITS-1:0]    last_new;
    logic                   fire;

    assign work_idx  = work_reg.stream_id[IDX_BITS-1:0];
    assign pop_ready = state_reg == ST_FETCH;
    assign ram_raddr = (state_reg == ST_FETCH) ? pop_rec.stream_id[IDX_BITS-1:0] : work_idx;

    sfl_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (STREAMS)
    ) u_table (
        .clk   (clk),
        .we    (fire),
        .waddr (work_idx),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        seen     = seen_reg[work_idx];
        last_seq = ram_rdata[SEQ_BITS-1:0];
        lost_old = seen ? ram_rdata[ENTRY_BITS-1:SEQ_BITS] : '0;
        expected = seen ? ({1'b0, last_seq} + 1'b1) : '0;
        seq_ext  = {1'b0, work_reg.seq_no};
        priority if (seq_ext == expected)
        begin
            cls      = CLS_IN_ORDER;
            delta    = '0;
            last_new = work_reg.seq_no;
        end
        else if (seq_ext > expected)
        begin
            cls      = CLS_GAP;
            delta    = DELTA_BITS'(seq_ext - expected);
            last_new = work_reg.seq_no;
        end
        else
        begin
            cls      = CLS_LATE;
            delta    = '1;
            last_new = last_seq;
        end
        lost_new   = lost_old + {{(CNT_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};
        ram_wdata  = {lost_new, last_new};
        fire       = (state_reg == ST_EXEC) && (!out_valid_reg || result.ready);
        state_next = state_reg;
        unique case (state_reg)
            ST_FETCH:
            begin
                if (pop_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                out_valid_reg      <= 1'b1;
                seen_reg[work_idx] <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FETCH) && pop_valid)
        begin
            work_reg <= pop_rec;
        end
        if (fire)
        begin
            out_mismatch_reg <= work_reg.addr_mismatch;
            out_delay_reg    <= work_reg.path_delay;
            out_derr_reg     <= work_reg.delay_error;
            out_class_reg    <= cls;
            out_total_reg    <= lost_new;
            out_delta_reg    <= delta;
            out_stream_reg   <= work_reg.stream_id;
            out_prio_reg     <= work_reg.priority_req;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.addr_mismatch = out_mismatch_reg;
    assign result.path_delay    = out_delay_reg;
    assign result.delay_error   = out_derr_reg;
    assign result.frame_class   = out_class_reg;
    assign result.lost_total    = out_total_reg;
    assign result.lost_delta    = out_delta_reg;
    assign result.out_stream    = out_stream_reg;
    assign result.out_priority  = out_prio_reg;
endmodule

>>> rtl/core/stream_frame_loss_monitor.sv
// Top level of the stream frame loss monitor.
//
// Frame descriptors arrive as items on the frame channel (valid/ready) and
// one result item per frame leaves on the result channel (valid/ready).
// The own MAC address, written through cfg_wr_en and cfg_wr_data, resets to
// zero. The user writes it only while the block is idle; nothing enforces it.
// The front part checks the destination address and computes the path delay
// in the cycle an item is accepted and places it in a two-entry queue.
// The back part tracks each stream in a 256-entry table with a registered
// read port and works on one item at a time, in a fetch and an execute state.
// Items pass through the queue, the work register and the result register.
// Reset clears the queue, the result register and the per-stream seen bits,
// so no clearing pass is needed.
// When the receiver stalls, the result register holds its item, the back part
// waits, and the queue fills before the frame channel drops ready.
module stream_frame_loss_monitor
    import sfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [MAC_BITS-1:0] cfg_wr_data,
    sfl_frame_if.sink           frame,
    sfl_result_if.source        result
);
    logic       push_valid;
    logic       push_ready;
    front_rec_t push_rec;
    logic       pop_valid;
    logic       pop_ready;
    front_rec_t pop_rec;

    sfl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .frame       (frame),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_rec    (push_rec)
    );

    sfl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    sfl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec),
        .result    (result)
    );
endmodule

>>> rtl/core/sfl_checker.sv
// Port-level checker of the stream frame loss monitor and its bind statement.
module sfl_checker
    import sfl_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         valid,
    input logic                         ready,
    input logic [DELAY_BITS-1:0]        path_delay,
    input logic                         delay_error,
    input logic [CLASS_BITS-1:0]        frame_class,
    input logic signed [CNT_BITS-1:0]   lost_total,
    input logic signed [DELTA_BITS-1:0] lost_delta
);
    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (frame_class == CLS_IN_ORDER || frame_class == CLS_GAP
                   || frame_class == CLS_LATE))
        else $error("Result item carries an unused frame class code.");

    a_in_order_delta: assert property (@(posedge clk) disable iff (!rst_n)
        valid && frame_class == CLS_IN_ORDER |-> lost_delta == '0)
        else $error("An in-order frame counted lost frames.");

    a_late_delta: assert property (@(posedge clk) disable iff (!rst_n)
        valid && frame_class == CLS_LATE |-> lost_delta == '1)
        else $error("A late frame did not subtract exactly one.");

    a_delay_error: assert property (@(posedge clk) disable iff (!rst_n)
        valid && delay_error |-> path_delay == '0)
        else $error("A frame with a delay error reports a nonzero delay.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(lost_total) && $stable(frame_class))
        else $error("A stalled result item changed before it was taken.");
endmodule

bind stream_frame_loss_monitor sfl_checker u_sfl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .path_delay  (result.path_delay),
    .delay_error (result.delay_error),
    .frame_class (result.frame_class),
    .lost_total  (result.lost_total),
    .lost_delta  (result.lost_delta)
);
